### rtl/awid_pkg.sv
// Package for the 4-to-5 horizontal widener: pixel and group types,
// output slot codes and the per-channel interpolation function.
// No dependencies.
package awid_pkg;

    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = CH_W * NUM_CH;
    localparam int NUM_HELD = 3;
    localparam int SLOT_W   = 3;

    // output slot within a group of five
    localparam logic [SLOT_W-1:0] SLOT_P0  = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_Q1  = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_H2  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_Q3  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_P3  = 3'd4;

    // group position codes
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic color;
        pix_t p3;
        pix_t p2;
        pix_t p1;
        pix_t p0;
    } group_t;

    function automatic logic [CH_W-1:0] interp_ch(
        input logic [SLOT_W-1:0] slot,
        input logic [CH_W-1:0]   a,
        input logic [CH_W-1:0]   b,
        input logic [CH_W-1:0]   c,
        input logic [CH_W-1:0]   d
    );
        logic [CH_W+1:0] sum;
        logic [CH_W-1:0] res;
        sum = '0;
        unique case (slot)
            SLOT_P0: res = a;
            SLOT_Q1:
            begin
                sum = {2'b00, b} + {1'b0, b, 1'b0} + {2'b00, a};
                res = sum[CH_W+1:2];
            end
            SLOT_H2:
            begin
                sum = {2'b00, c} + {2'b00, b};
                res = sum[CH_W:1];
            end
            SLOT_Q3:
            begin
                sum = {2'b00, d} + {1'b0, c, 1'b0} + {2'b00, c};
                res = sum[CH_W+1:2];
            end
            SLOT_P3: res = d;
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic pix_t interp_pix(
        input logic [SLOT_W-1:0] slot,
        input group_t            grp
    );
        pix_t res;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            res[ch*CH_W +: CH_W] = interp_ch(slot,
                grp.p0[ch*CH_W +: CH_W], grp.p1[ch*CH_W +: CH_W],
                grp.p2[ch*CH_W +: CH_W], grp.p3[ch*CH_W +: CH_W]);
        end
        // grey mode keeps channel 0 only
        if (!grp.color) begin
            res[PIX_W-1:CH_W] = '0;
        end
        return res;
    endfunction

endpackage

### rtl/awid_gather.sv
// Input side of the widener: holds the first three pixels of a group and
// loads a complete group register on the fourth. Uses awid_pkg.
module awid_gather (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  awid_pkg::pix_t s_axis_tdata,    // ch0 [7:0], ch1 [15:8], ch2 [23:16]
    input  logic          s_axis_tuser,     // start_of_row
    input  logic          color_mode,
    input  logic          grp_take,
    output logic          grp_valid,
    output awid_pkg::group_t grp
);
    import awid_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  eff_pos;
    pix_t        held_reg [NUM_HELD];
    group_t      grp_reg, grp_next;
    logic        grp_valid_reg, grp_valid_next;
    logic        accept;
    logic        slot_free;

    assign slot_free     = !grp_valid_reg || grp_take;
    assign s_axis_tready = (pos_reg != POS_FOURTH) || slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign eff_pos       = s_axis_tuser ? POS_FIRST : pos_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg && !grp_take;
        if (accept) begin
            if (eff_pos == POS_FOURTH) begin
                pos_next       = POS_FIRST;
                grp_next.p0    = held_reg[0];
                grp_next.p1    = held_reg[1];
                grp_next.p2    = held_reg[2];
                grp_next.p3    = s_axis_tdata;
                grp_next.color = color_mode;
                grp_valid_next = 1'b1;
            end else begin
                pos_next = eff_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= POS_FIRST;
            grp_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
        if (accept) begin
            unique case (eff_pos)
                POS_FIRST:  held_reg[0] <= s_axis_tdata;
                POS_SECOND: held_reg[1] <= s_axis_tdata;
                POS_THIRD:  held_reg[2] <= s_axis_tdata;
                POS_FOURTH: ;
            endcase
        end
    end

    assign grp_valid = grp_valid_reg;
    assign grp       = grp_reg;

endmodule

### rtl/awid_emit.sv
// Output side of the widener, using awid_pkg, steps through the five slots of a
// group, interpolating one pixel per unstalled cycle into the output register.
module awid_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             grp_valid,
    input  awid_pkg::group_t grp,
    output logic             grp_take,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output awid_pkg::pix_t   m_axis_tdata,  // ch0 [7:0], ch1 [15:8], ch2 [23:16]
    output logic             m_axis_tlast   // last_of_group
);
    import awid_pkg::*;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              tvalid_reg, tvalid_next;
    pix_t              tdata_reg;
    logic              tlast_reg;
    logic              load;

    assign load     = grp_valid && (!tvalid_reg || m_axis_tready);
    assign grp_take = load && (slot_reg == SLOT_P3);

    always_comb
    begin
        slot_next   = slot_reg;
        tvalid_next = tvalid_reg && !m_axis_tready;
        if (load) begin
            tvalid_next = 1'b1;
            slot_next   = (slot_reg == SLOT_P3) ? SLOT_P0 : slot_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slot_reg   <= SLOT_P0;
            tvalid_reg <= 1'b0;
        end else begin
            slot_reg   <= slot_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            tdata_reg <= interp_pix(slot_reg, grp);
            tlast_reg <= (slot_reg == SLOT_P3);
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule

### rtl/aspect_widen_4_to_5_core.sv
// Channel   | Dir | Handshake              | Payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: ch0,ch1,ch2; tuser: start_of_row
// m_axis    | out | m_axis_tvalid/tready   | tdata: ch0,ch1,ch2; tlast: last_of_group
// cfg       | in  | cfg_valid/cfg_ready    | cfg_data: color_mode
//
// Four pixels in give five pixels out; one output pixel per cycle while m_axis_tready
// holds, so the sustained intake is four pixels per five output pixels, set by the output register.
// A pixel is taken every cycle while a group waits, except the fourth pixel
// of the next group, which waits until the group register frees up.
// First output passes the group register, then the output register. Async reset clears
// the group position, valid flags and color_mode; cfg is always ready.
// Top level of the widener; uses awid_pkg, awid_gather and awid_emit.
module aspect_widen_4_to_5_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  awid_pkg::pix_t s_axis_tdata,   // pixel_ch0 [7:0], pixel_ch1 [15:8], pixel_ch2 [23:16]
    input  logic           s_axis_tuser,   // start_of_row
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output awid_pkg::pix_t m_axis_tdata,   // out_ch0 [7:0], out_ch1 [15:8], out_ch2 [23:16]
    output logic           m_axis_tlast,   // last_of_group
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data        // color_mode
);
    import awid_pkg::*;

    logic   color_mode_reg;
    logic   grp_valid;
    logic   grp_take;
    group_t grp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            color_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            color_mode_reg <= cfg_data;
        end
    end

    awid_gather u_gather (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .color_mode    (color_mode_reg),
        .grp_take      (grp_take),
        .grp_valid     (grp_valid),
        .grp           (grp)
    );

    awid_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .grp_valid     (grp_valid),
        .grp           (grp),
        .grp_take      (grp_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
